>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/prhc_pkg.sv
// ----------------------------------------------------------------------------
// prhc_pkg
// Types, constants and command structures for the polygon region heading cost
// block.
// ----------------------------------------------------------------------------
package prhc_pkg;

   localparam int DefMaxRegions  = 8;
   localparam int DefMaxVertices = 16;
   localparam int DefMaxSteps    = 64;

   localparam logic signed [17:0] AngPi    = 18'sd25736;
   localparam logic signed [17:0] AngTwoPi = 18'sd51472;

   localparam int ReqDataW = 112;
   localparam int RspDataW = 40;

   typedef enum logic [1:0] {
      MODE_VERTEX = 2'd0,
      MODE_ATTR   = 2'd1,
      MODE_POSE   = 2'd2,
      MODE_YAW    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ENABLE       = 2'd0,
      CSR_COST_POWER   = 2'd1,
      CSR_REGION_COUNT = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REGION,
      ST_EDGE_RD,
      ST_EDGE_WAIT,
      ST_EDGE_MUL,
      ST_EDGE_CMP,
      ST_POSE_DONE,
      ST_COST_BASE,
      ST_COST_DIV,
      ST_COST_POW_MUL,
      ST_COST_POW_ADD,
      ST_COST_DONE,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;       // latch the request payload
      logic do_load;       // perform a vertex or attribute write
      logic do_yaw;        // accumulate one yaw sample
      logic pose_start;    // clear search state
      logic edge_read;     // issue vertex reads for the current edge
      logic edge_mul;      // form cross products
      logic edge_cmp;      // compare and toggle parity
      logic region_next;   // advance region, clear parity
      logic pose_found;    // take current region as active
      logic base_start;    // form dividend and start divider
      logic div_step;      // one restoring division step
      logic pow_init;      // set accumulator to one
      logic pow_mul;       // form acc * base
      logic pow_add;       // round, shift, clamp
      logic make_pose_rsp; // load pose result
      logic make_cost_rsp; // load cost result
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     last_sample;
      logic     region_valid;  // current region can hold a point
      logic     region_more;   // current region below the limit
      logic     edge_last;     // current edge is the final one
      logic     parity;        // parity of current region
      logic     div_done;
      logic     pow_done;
      logic     cost_zero;     // cost forced to zero
   } sts_type;

endpackage

>>> rtl/prhc_ram.sv
// ----------------------------------------------------------------------------
// prhc_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module prhc_ram #(
   parameter int Width = 64,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/prhc_ctrl.sv
// ----------------------------------------------------------------------------
// prhc_ctrl
// Controller: sequences loads, the region and edge walk of a pose search and
// the division and power steps of a trajectory cost.
// ----------------------------------------------------------------------------
module prhc_ctrl import prhc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_fire,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_pending
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      rsp_pending = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in = ST_REGION;
            end
         end
         ST_REGION: begin
            // first cycle after capture also dispatches on mode
            unique case (sts.mode)
               MODE_VERTEX, MODE_ATTR: begin
                  cmd.do_load = 1'b1;
                  state_in = ST_IDLE;
               end
               MODE_YAW: begin
                  cmd.do_yaw = 1'b1;
                  if (sts.last_sample) begin
                     state_in = ST_COST_BASE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               MODE_POSE: begin
                  cmd.pose_start = 1'b1;
                  state_in = ST_EDGE_RD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_EDGE_RD: begin
            priority if (!sts.region_more) begin
               state_in = ST_POSE_DONE;
            end else if (!sts.region_valid) begin
               cmd.region_next = 1'b1;
            end else begin
               cmd.edge_read = 1'b1;
               state_in = ST_EDGE_WAIT;
            end
         end
         ST_EDGE_WAIT: state_in = ST_EDGE_MUL;
         ST_EDGE_MUL: begin
            cmd.edge_mul = 1'b1;
            state_in = ST_EDGE_CMP;
         end
         ST_EDGE_CMP: begin
            cmd.edge_cmp = 1'b1;
            state_in = sts.edge_last ? ST_COST_DONE : ST_EDGE_RD;
         end
         ST_COST_DONE: begin
            // region finished: parity settled
            if (sts.parity) begin
               cmd.pose_found = 1'b1;
               state_in = ST_POSE_DONE;
            end else begin
               cmd.region_next = 1'b1;
               state_in = ST_EDGE_RD;
            end
         end
         ST_POSE_DONE: begin
            cmd.make_pose_rsp = 1'b1;
            state_in = ST_OUT;
         end
         ST_COST_BASE: begin
            cmd.base_start = 1'b1;
            state_in = ST_COST_DIV;
         end
         ST_COST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_COST_POW_MUL;
               cmd.pow_init = 1'b1;
               cmd.div_step = 1'b0;
            end
         end
         ST_COST_POW_MUL: begin
            if (sts.pow_done) begin
               cmd.make_cost_rsp = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.pow_mul = 1'b1;
               state_in = ST_COST_POW_ADD;
            end
         end
         ST_COST_POW_ADD: begin
            cmd.pow_add = 1'b1;
            state_in = ST_COST_POW_MUL;
         end
         ST_OUT: begin
            rsp_pending = 1'b1;
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> rtl/prhc_datapath.sv
// ----------------------------------------------------------------------------
// prhc_datapath
// Datapath: region tables, vertex RAM, edge crossing test, yaw accumulator,
// restoring divider for the mean and the power multiplier.
// ----------------------------------------------------------------------------
module prhc_datapath import prhc_pkg::*; #(
   parameter int MaxRegions  = DefMaxRegions,
   parameter int MaxVertices = DefMaxVertices,
   parameter int MaxSteps    = DefMaxSteps
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [ReqDataW-1:0] req_data,
   input  logic                req_last,
   input  logic                cfg_enable,
   input  logic [2:0]          cfg_power,
   input  logic [3:0]          cfg_regions,
   output sts_type             sts,
   output logic [RspDataW-1:0] rsp_data
);
   localparam int RegW   = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
   localparam int VtxW   = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
   localparam int AddrW  = $clog2(MaxRegions * MaxVertices);
   localparam int CntW   = $clog2(MaxSteps + 1);
   localparam int SumW   = CntW + 15;
   localparam int DivW   = SumW + 16 + 1;  // dividend width with rounding term
   localparam int DstW   = $clog2(DivW + 1);
   localparam int VcW    = $clog2(MaxVertices + 1);
   localparam int RcW    = RegW + 1;

   // captured request
   logic [1:0]         mode_ff;
   logic [2:0]         reg_idx_ff;
   logic [3:0]         vtx_idx_ff;
   logic signed [31:0] x_ff, y_ff;
   logic [15:0]        angle_ff, weight_ff;
   logic [4:0]         vcount_ff;
   logic               last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_data[1:0];
         reg_idx_ff <= req_data[4:2];
         vtx_idx_ff <= req_data[8:5];
         x_ff       <= req_data[40:9];
         y_ff       <= req_data[72:41];
         angle_ff   <= req_data[88:73];
         weight_ff  <= req_data[104:89];
         vcount_ff  <= req_data[109:105];
         last_ff    <= req_last;
      end
   end

   // region attribute tables, read at one address each
   logic [15:0] head_ff  [MaxRegions];
   logic [15:0] wgt_ff   [MaxRegions];
   logic [4:0]  nvert_ff [MaxRegions];

   logic attr_ok, vtx_ok;
   assign attr_ok = ({29'd0, reg_idx_ff} < 32'(MaxRegions));
   assign vtx_ok  = attr_ok && ({28'd0, vtx_idx_ff} < 32'(MaxVertices));

   always_ff @(posedge clock) begin
      if (cmd.do_load && mode_ff == MODE_ATTR && attr_ok) begin
         head_ff[reg_idx_ff[RegW-1:0]]  <= angle_ff;
         wgt_ff[reg_idx_ff[RegW-1:0]]   <= weight_ff;
         nvert_ff[reg_idx_ff[RegW-1:0]] <= vcount_ff;
      end
   end

   // search state
   logic [RcW-1:0] region_ff;
   logic [VcW-1:0] edge_ff;
   logic           parity_ff;
   logic [RcW-1:0] limit;
   logic [VcW-1:0] nv;
   logic [4:0]     nv_raw;

   assign limit  = ({28'd0, cfg_regions} < 32'(MaxRegions)) ?
                   RcW'(cfg_regions) : RcW'(MaxRegions);
   assign nv_raw = nvert_ff[region_ff[RegW-1:0]];
   assign nv     = ({27'd0, nv_raw} > 32'(MaxVertices)) ? VcW'(MaxVertices) :
                   VcW'(nv_raw);

   // vertex RAM: edge i uses vertex i and vertex j = previous (wraps to n-1)
   logic           ram_we;
   logic [AddrW-1:0] ram_wa, ram_ra;
   logic [63:0]    ram_rd;
   logic           rd_sel_ff;  // 0 reads vi, 1 reads vj
   logic [63:0]    vi_ff;
   logic           vi_valid_ff;
   logic [VcW-1:0] jdx;

   assign ram_we = cmd.do_load && mode_ff == MODE_VERTEX && vtx_ok;
   assign ram_wa = AddrW'({reg_idx_ff[RegW-1:0], vtx_idx_ff[VtxW-1:0]});
   assign jdx    = (edge_ff == '0) ? nv - VcW'(1) : edge_ff - VcW'(1);
   assign ram_ra = rd_sel_ff ?
                   AddrW'({region_ff[RegW-1:0], jdx[VtxW-1:0]}) :
                   AddrW'({region_ff[RegW-1:0], edge_ff[VtxW-1:0]});

   prhc_ram #(.Width(64), .Depth(MaxRegions * MaxVertices)) u_vram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data ({x_ff, y_ff}),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // edge arithmetic
   logic signed [31:0] xi, yi, xj, yj;
   logic signed [32:0] a0, b0, c0, dy;
   logic signed [65:0] p_ff, q_ff;
   logic signed [32:0] dy_ff;
   logic               cross_ff;

   assign xi = vi_ff[63:32];
   assign yi = vi_ff[31:0];
   assign xj = ram_rd[63:32];
   assign yj = ram_rd[31:0];
   assign a0 = 33'(x_ff) - 33'(xi);
   assign dy = 33'(yj) - 33'(yi);
   assign b0 = 33'(xj) - 33'(xi);
   assign c0 = 33'(y_ff) - 33'(yi);

   // vi is read first, then vj; sequence: read vi (EDGE_RD), read vj (WAIT)
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff <= 1'b0;
      end else if (cmd.edge_read) begin
         rd_sel_ff <= 1'b1;
      end else begin
         rd_sel_ff <= 1'b0;
      end
      vi_valid_ff <= cmd.edge_read;
      if (vi_valid_ff) begin
         vi_ff <= ram_rd;
      end
      if (cmd.edge_mul) begin
         p_ff     <= a0 * dy;
         q_ff     <= b0 * c0;
         dy_ff    <= dy;
         cross_ff <= (yi > y_ff) != (yj > y_ff);
      end
   end

   logic flip;
   assign flip = cross_ff && (((dy_ff > 0) && (p_ff < q_ff)) ||
                              ((dy_ff < 0) && (p_ff > q_ff)));

   // active region and trajectory state
   logic          act_valid_ff;
   logic [15:0]   act_head_ff, act_wgt_ff;
   logic [RegW-1:0] found_ff;
   logic [SumW-1:0] sum_ff;
   logic [CntW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         act_head_ff  <= '0;
         act_wgt_ff   <= '0;
         found_ff     <= '0;
         region_ff    <= '0;
         edge_ff      <= '0;
         parity_ff    <= 1'b0;
      end else begin
         if (cmd.pose_start) begin
            act_valid_ff <= 1'b0;
            act_head_ff  <= '0;
            act_wgt_ff   <= '0;
            found_ff     <= '0;
            region_ff    <= '0;
            edge_ff      <= '0;
            parity_ff    <= 1'b0;
         end
         if (cmd.region_next) begin
            region_ff <= region_ff + RcW'(1);
            edge_ff   <= '0;
            parity_ff <= 1'b0;
         end
         if (cmd.edge_cmp) begin
            edge_ff <= edge_ff + VcW'(1);
            if (flip) begin
               parity_ff <= ~parity_ff;
            end
         end
         if (cmd.pose_found) begin
            act_valid_ff <= 1'b1;
            act_head_ff  <= head_ff[region_ff[RegW-1:0]];
            act_wgt_ff   <= wgt_ff[region_ff[RegW-1:0]];
            found_ff     <= region_ff[RegW-1:0];
         end
      end
   end

   // heading error: wrap (-pi, pi] then take the magnitude
   logic signed [17:0] hd, w1;
   logic        [14:0] herr;
   always_comb begin
      hd = 18'(signed'(act_head_ff)) - 18'(signed'(angle_ff));
      priority if (hd > AngPi) begin
         w1 = hd - AngTwoPi;
      end else if (hd <= -AngPi) begin
         w1 = hd + AngTwoPi;
      end else begin
         w1 = hd;
      end
      herr = (w1 < 0) ? 15'(-w1) : 15'(w1);
   end

   // division: base = (sum*w + 16*n) / (32*n), restoring, one bit a cycle
   logic [DivW-1:0]    rem_ff, quo_ff;
   logic [CntW+4:0]    dvs_ff;
   logic [DstW-1:0]    dstep_ff;
   logic [DivW:0]      trial;
   assign trial = {rem_ff, quo_ff[DivW-1]} - {{(DivW-CntW-4){1'b0}}, dvs_ff};

   // power: acc = min((acc*base + 0x8000) >> 16, 2^32-1)
   logic [32:0]  base_ff;
   logic [31:0]  acc_ff;
   logic [64:0]  prod_ff;
   logic [2:0]   pw_ff;
   logic [48:0]  rnd;
   assign rnd = prod_ff[64:16] + 49'(prod_ff[15]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.pose_start) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end
         if (cmd.do_yaw && (32'(cnt_ff) < MaxSteps)) begin
            sum_ff <= sum_ff + SumW'(herr);
            cnt_ff <= cnt_ff + CntW'(1);
         end
         if (cmd.make_cost_rsp) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end
      end
      if (cmd.base_start) begin
         rem_ff   <= '0;
         quo_ff   <= DivW'(sum_ff) * DivW'(act_wgt_ff) + DivW'({cnt_ff, 4'd0});
         dvs_ff   <= {cnt_ff, 5'd0};
         dstep_ff <= '0;
      end
      if (cmd.div_step) begin
         dstep_ff <= dstep_ff + DstW'(1);
         if (!trial[DivW]) begin
            rem_ff <= trial[DivW-1:0];
            quo_ff <= {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DivW-2:0], quo_ff[DivW-1]};
            quo_ff <= {quo_ff[DivW-2:0], 1'b0};
         end
      end
      if (cmd.pow_init) begin
         base_ff <= 33'(quo_ff);
         acc_ff  <= 32'h0001_0000;
         pw_ff   <= '0;
      end
      if (cmd.pow_mul) begin
         prod_ff <= 65'(acc_ff) * 65'(base_ff);
      end
      if (cmd.pow_add) begin
         acc_ff <= (rnd[48:32] != '0) ? 32'hFFFF_FFFF : rnd[31:0];
         pw_ff  <= pw_ff + 3'd1;
      end
   end

   // result register
   logic [RspDataW-1:0] rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.make_pose_rsp) begin
         rsp_ff <= RspDataW'({32'd0, 3'(found_ff) & {3{act_valid_ff}}, act_valid_ff,
                              1'b0});
      end
      if (cmd.make_cost_rsp) begin
         rsp_ff <= RspDataW'({(sts.cost_zero ? 32'd0 : acc_ff), 3'd0, 1'b0, 1'b1});
      end
   end
   assign rsp_data = rsp_ff;

   always_comb begin
      sts.mode         = mode_type'(mode_ff);
      sts.last_sample  = last_ff;
      sts.region_more  = region_ff < limit;
      sts.region_valid = nv_raw >= 5'd3;
      sts.edge_last    = (edge_ff + VcW'(1)) == nv;
      sts.parity       = parity_ff;
      sts.div_done     = 32'(dstep_ff) == DivW;
      sts.pow_done     = pw_ff == cfg_power;
      sts.cost_zero    = !cfg_enable || !act_valid_ff || act_wgt_ff == '0 ||
                         cnt_ff == '0;
   end
endmodule

>>> rtl/polygon_region_heading_cost_top.sv
// ----------------------------------------------------------------------------
// polygon_region_heading_cost_top
// Point-in-polygon region search with a heading cost over yaw trajectories.
//
// channel | dir | fields
// req     | in  | tdata: mode, region_index, vertex_index, coord_x, coord_y,
//         |     |        angle, weight, vertex_count; tlast: last_sample
// rsp     | out | tdata: in_region, found_region, cost; tuser: result_kind
// csr     | in  | index 0 enable, 1 power, 2 region_count
//
// A pose walks the polygon edges of each region one at a time through the
// vertex RAM read port. A last yaw adds a 39-step bit-serial division and a
// multiply and an add per power step. Reset is synchronous and clears
// control, search, trajectory and CSR state only. Results wait in the output
// register until taken; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module polygon_region_heading_cost_top import prhc_pkg::*; #(
   parameter int MaxRegions  = DefMaxRegions,
   parameter int MaxVertices = DefMaxVertices,
   parameter int MaxSteps    = DefMaxSteps
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // mode[1:0] region_index[4:2] vertex_index[8:5] coord_x[40:9]
   // coord_y[72:41] angle[88:73] weight[104:89] vertex_count[109:105]
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // in_region[0] found_region[3:1] cost[35:4]
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tuser,  // result_kind
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic busy, pending;
   logic [RspDataW-1:0] raw;

   logic       enable_ff;
   logic [2:0] power_ff;
   logic [3:0] count_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         power_ff  <= 3'd1;
         count_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:       enable_ff <= csr_data[0];
            CSR_COST_POWER:   power_ff  <= csr_data[2:0];
            CSR_REGION_COUNT: count_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !busy;
   assign rsp_tvalid = pending;
   assign rsp_tuser  = raw[0];
   assign rsp_tdata  = {4'd0, raw[36:1]};

   prhc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_tvalid && req_tready),
      .rsp_fire    (rsp_tvalid && rsp_tready),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_pending (pending)
   );

   prhc_datapath #(
      .MaxRegions  (MaxRegions),
      .MaxVertices (MaxVertices),
      .MaxSteps    (MaxSteps)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_tdata),
      .req_last    (req_tlast),
      .cfg_enable  (enable_ff),
      .cfg_power   (power_ff),
      .cfg_regions (count_ff),
      .sts         (sts),
      .rsp_data    (raw)
   );
endmodule

>>> rtl/prhc_checker.sv
// ----------------------------------------------------------------------------
// prhc_checker
// Port-level checks on the polygon region heading cost block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module prhc_checker import prhc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tuser
);
   `ASSERT_IMPL(a_cost_clean, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[3:0] == 4'd0, "cost result carries region bits")
   `ASSERT_IMPL(a_pose_clean, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[35:4] == 32'd0, "pose result carries a cost")
   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "request taken while a result waits")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
endmodule

bind polygon_region_heading_cost_top prhc_checker u_prhc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
